### rtl/cfs_pkg.sv
package cfs_pkg;

  // cube face codes, positive then negative per axis
  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

endpackage

### rtl/cfs_dir_if.sv
interface cfs_dir_if #(
  parameter int COMPONENT_BITS = 16
) ();
  logic                             valid;
  logic                             ready;
  logic signed [COMPONENT_BITS-1:0] x_component;
  logic signed [COMPONENT_BITS-1:0] y_component;
  logic signed [COMPONENT_BITS-1:0] z_component;

  modport source (
    output valid, x_component, y_component, z_component,
    input  ready
  );

  modport sink (
    input  valid, x_component, y_component, z_component,
    output ready
  );
endinterface

### rtl/cfs_face_if.sv
interface cfs_face_if #(
  parameter int FRACTION_BITS = 14
) ();
  logic                            valid;
  logic                            ready;
  logic [2:0]                      face_index;
  logic signed [FRACTION_BITS+1:0] u_coord;
  logic signed [FRACTION_BITS+1:0] v_coord;
  logic                            degenerate;

  modport source (
    output valid, face_index, u_coord, v_coord, degenerate,
    input  ready
  );

  modport sink (
    input  valid, face_index, u_coord, v_coord, degenerate,
    output ready
  );
endinterface

### rtl/cubemap_face_select_core.sv
// Cube map face selection, one direction vector per transfer.
// dir carries x, y and z as signed components of one common scale; res
// carries the face (0 +x, 1 -x, 2 +y, 3 -y, 4 +z, 5 -z), u and v in
// signed Q1.FRACTION_BITS and a flag for the all-zero vector, which gives
// face 5 with u = v = 0.
// Both channels use valid/ready; a transfer happens on a clock edge with
// both high.
// The pipeline has two classify stages, one numerator set-up stage,
// FRACTION_BITS + 1 restoring divide stages (one quotient bit per stage for
// u and v side by side) and the output register. Throughput is one transfer
// per cycle while res is not stalled.
// Every stage holds its own valid bit and ready is passed back stage by
// stage, so while res is stalled the pipeline keeps taking transfers
// until every stage is full; nothing is dropped or repeated.
// Synchronous reset empties all stages; no result is pending afterwards.
module cubemap_face_select_core import cfs_pkg::*; #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRACTION_BITS  = 14
) (
  input logic            clk,
  input logic            rst,
  cfs_dir_if.sink        dir,
  cfs_face_if.source     res
);

  localparam int C     = COMPONENT_BITS;
  localparam int F     = FRACTION_BITS;
  localparam int STEPS = FRACTION_BITS + 1;
  localparam int NW    = COMPONENT_BITS + FRACTION_BITS + 1;

  // classify to set-up
  logic         cl_valid, cl_ready;
  face_t        cl_face;
  logic [C-1:0] cl_major, cl_u_mag, cl_v_mag;
  logic         cl_u_neg, cl_v_neg, cl_degen;

  // set-up register
  logic         su_valid;
  face_t        su_face;
  logic         su_degen;
  logic [C-1:0] su_divisor, su_rem_u, su_rem_v;
  logic [F:0]   su_num_u, su_num_v;
  logic         su_neg_u, su_neg_v;

  // divide chain, entry 0 is the set-up register
  logic         ch_valid   [STEPS+1];
  logic         ch_ready   [STEPS+1];
  face_t        ch_face    [STEPS+1];
  logic         ch_degen   [STEPS+1];
  logic [C-1:0] ch_divisor [STEPS+1];
  logic [C-1:0] ch_rem_u   [STEPS+1];
  logic [C-1:0] ch_rem_v   [STEPS+1];
  logic [F:0]   ch_num_u   [STEPS+1];
  logic [F:0]   ch_num_v   [STEPS+1];
  logic [F:0]   ch_quot_u  [STEPS+1];
  logic [F:0]   ch_quot_v  [STEPS+1];
  logic         ch_neg_u   [STEPS+1];
  logic         ch_neg_v   [STEPS+1];

  logic [NW-1:0] numer_u, numer_v;
  logic [F+1:0]  quot_ext_u, quot_ext_v;
  logic          o_valid, o_ready;

  cfs_classify #(
    .COMPONENT_BITS (C)
  ) u_classify (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (dir.valid),
    .up_ready    (dir.ready),
    .x_component (dir.x_component),
    .y_component (dir.y_component),
    .z_component (dir.z_component),
    .dn_valid    (cl_valid),
    .dn_ready    (cl_ready),
    .face        (cl_face),
    .major_mag   (cl_major),
    .u_mag       (cl_u_mag),
    .v_mag       (cl_v_mag),
    .u_neg       (cl_u_neg),
    .v_neg       (cl_v_neg),
    .degenerate  (cl_degen)
  );

  // rounded numerator |n| * 2^F + m/2; its top bits stay below m
  assign numer_u = {1'b0, cl_u_mag, {F{1'b0}}} + NW'(cl_major >> 1);
  assign numer_v = {1'b0, cl_v_mag, {F{1'b0}}} + NW'(cl_major >> 1);

  assign cl_ready = !su_valid || ch_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      su_valid <= 1'b0;
    end else if (cl_ready) begin
      su_valid <= cl_valid;
    end
    if (cl_valid && cl_ready) begin
      su_face    <= cl_face;
      su_degen   <= cl_degen;
      su_divisor <= cl_major;
      su_rem_u   <= numer_u[NW-1:F+1];
      su_rem_v   <= numer_v[NW-1:F+1];
      su_num_u   <= numer_u[F:0];
      su_num_v   <= numer_v[F:0];
      su_neg_u   <= cl_u_neg;
      su_neg_v   <= cl_v_neg;
    end
  end

  assign ch_valid[0]   = su_valid;
  assign ch_face[0]    = su_face;
  assign ch_degen[0]   = su_degen;
  assign ch_divisor[0] = su_divisor;
  assign ch_rem_u[0]   = su_rem_u;
  assign ch_rem_v[0]   = su_rem_v;
  assign ch_num_u[0]   = su_num_u;
  assign ch_num_v[0]   = su_num_v;
  assign ch_quot_u[0]  = '0;
  assign ch_quot_v[0]  = '0;
  assign ch_neg_u[0]   = su_neg_u;
  assign ch_neg_v[0]   = su_neg_v;

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    cfs_div_step #(
      .COMPONENT_BITS (C),
      .FRACTION_BITS  (F)
    ) u_step (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (ch_valid[s]),
      .up_ready   (ch_ready[s]),
      .up_face    (ch_face[s]),
      .up_degen   (ch_degen[s]),
      .up_divisor (ch_divisor[s]),
      .up_rem_u   (ch_rem_u[s]),
      .up_rem_v   (ch_rem_v[s]),
      .up_num_u   (ch_num_u[s]),
      .up_num_v   (ch_num_v[s]),
      .up_quot_u  (ch_quot_u[s]),
      .up_quot_v  (ch_quot_v[s]),
      .up_neg_u   (ch_neg_u[s]),
      .up_neg_v   (ch_neg_v[s]),
      .dn_valid   (ch_valid[s+1]),
      .dn_ready   (ch_ready[s+1]),
      .dn_face    (ch_face[s+1]),
      .dn_degen   (ch_degen[s+1]),
      .dn_divisor (ch_divisor[s+1]),
      .dn_rem_u   (ch_rem_u[s+1]),
      .dn_rem_v   (ch_rem_v[s+1]),
      .dn_num_u   (ch_num_u[s+1]),
      .dn_num_v   (ch_num_v[s+1]),
      .dn_quot_u  (ch_quot_u[s+1]),
      .dn_quot_v  (ch_quot_v[s+1]),
      .dn_neg_u   (ch_neg_u[s+1]),
      .dn_neg_v   (ch_neg_v[s+1])
    );
  end

  // output register: sign applied, zero vector forced to the origin
  assign quot_ext_u       = {1'b0, ch_quot_u[STEPS]};
  assign quot_ext_v       = {1'b0, ch_quot_v[STEPS]};
  assign o_ready          = !o_valid || res.ready;
  assign ch_ready[STEPS]  = o_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_ready) begin
      o_valid <= ch_valid[STEPS];
    end
    if (ch_valid[STEPS] && o_ready) begin
      res.face_index <= ch_face[STEPS];
      res.degenerate <= ch_degen[STEPS];
      if (ch_degen[STEPS]) begin
        res.u_coord <= '0;
        res.v_coord <= '0;
      end else begin
        res.u_coord <= ch_neg_u[STEPS] ? -quot_ext_u : quot_ext_u;
        res.v_coord <= ch_neg_v[STEPS] ? -quot_ext_v : quot_ext_v;
      end
    end
  end

  assign res.valid = o_valid;

  // checks
  localparam logic signed [F+1:0] COORD_ONE = {2'b01, {F{1'b0}}};

  a_degen_origin: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.degenerate |->
      res.face_index == FACE_NEG_Z && res.u_coord == '0 && res.v_coord == '0)
    else $error("zero vector result not at face 5 origin");

  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |->
      res.u_coord <= COORD_ONE && res.u_coord >= -COORD_ONE &&
      res.v_coord <= COORD_ONE && res.v_coord >= -COORD_ONE)
    else $error("face coordinate outside [-1,1]");

  a_full_before_backpressure: assert property (@(posedge clk) disable iff (rst)
    !dir.ready |-> o_valid && ch_valid[0] && ch_valid[STEPS] && !res.ready)
    else $error("input stalled with room left in the pipeline");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_ready |=> o_valid)
    else $error("stalled result lost");

endmodule

### rtl/cfs_classify.sv
module cfs_classify import cfs_pkg::*; #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic signed [COMPONENT_BITS-1:0] x_component,
  input  logic signed [COMPONENT_BITS-1:0] y_component,
  input  logic signed [COMPONENT_BITS-1:0] z_component,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output face_t                            face,
  output logic [COMPONENT_BITS-1:0]        major_mag,
  output logic [COMPONENT_BITS-1:0]        u_mag,
  output logic [COMPONENT_BITS-1:0]        v_mag,
  output logic                             u_neg,
  output logic                             v_neg,
  output logic                             degenerate
);

  localparam int C = COMPONENT_BITS;

  // stage a: magnitudes, signs and zero flags
  logic         a_valid;
  logic [C-1:0] a_mag_x, a_mag_y, a_mag_z;
  logic         a_sign_x, a_sign_y, a_sign_z;
  logic         a_zero_x, a_zero_y, a_zero_z;
  logic         a_ready;

  // stage b: face choice and minor operands
  logic         b_valid;
  face_t        b_face;
  logic [C-1:0] b_major, b_u_mag, b_v_mag;
  logic         b_u_neg, b_v_neg, b_degen;
  logic         b_ready;

  face_t        face_next;
  logic [C-1:0] major_next, u_mag_next, v_mag_next;
  logic         u_sign, v_sign, u_flip, v_flip;
  logic         x_major, y_major;

  // most negative input still gives an exact unsigned magnitude
  function automatic logic [C-1:0] mag_of(input logic signed [C-1:0] val);
    mag_of = val[C-1] ? (~val + C'(1)) : val;
  endfunction

  assign b_ready  = !b_valid || dn_ready;
  assign a_ready  = !a_valid || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= up_valid;
    end
    if (up_valid && a_ready) begin
      a_mag_x  <= mag_of(x_component);
      a_mag_y  <= mag_of(y_component);
      a_mag_z  <= mag_of(z_component);
      a_sign_x <= x_component[C-1];
      a_sign_y <= y_component[C-1];
      a_sign_z <= z_component[C-1];
      a_zero_x <= (x_component == '0);
      a_zero_y <= (y_component == '0);
      a_zero_z <= (z_component == '0);
    end
  end

  // major axis by strict compare, ties go to the later axis
  assign x_major = (a_mag_x > a_mag_y) && (a_mag_x > a_mag_z);
  assign y_major = (a_mag_y > a_mag_z);

  always_comb begin
    if (x_major) begin
      face_next  = (!a_sign_x && !a_zero_x) ? FACE_POS_X : FACE_NEG_X;
      major_next = a_mag_x;
      u_mag_next = a_mag_z;
      v_mag_next = a_mag_y;
      u_sign     = a_sign_z;
      v_sign     = a_sign_y;
    end else if (y_major) begin
      face_next  = (!a_sign_y && !a_zero_y) ? FACE_POS_Y : FACE_NEG_Y;
      major_next = a_mag_y;
      u_mag_next = a_mag_x;
      v_mag_next = a_mag_z;
      u_sign     = a_sign_x;
      v_sign     = a_sign_z;
    end else begin
      face_next  = (!a_sign_z && !a_zero_z) ? FACE_POS_Z : FACE_NEG_Z;
      major_next = a_mag_z;
      u_mag_next = a_mag_x;
      v_mag_next = a_mag_y;
      u_sign     = a_sign_x;
      v_sign     = a_sign_y;
    end
  end

  // per-face sign flip of the two coordinates
  always_comb begin
    case (face_next)
      FACE_POS_X: begin u_flip = 1'b1; v_flip = 1'b1; end
      FACE_NEG_X: begin u_flip = 1'b0; v_flip = 1'b1; end
      FACE_POS_Y: begin u_flip = 1'b0; v_flip = 1'b0; end
      FACE_NEG_Y: begin u_flip = 1'b0; v_flip = 1'b1; end
      FACE_POS_Z: begin u_flip = 1'b0; v_flip = 1'b1; end
      FACE_NEG_Z: begin u_flip = 1'b1; v_flip = 1'b1; end
      default:    begin u_flip = 1'b0; v_flip = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (a_valid && b_ready) begin
      b_face  <= face_next;
      b_major <= major_next;
      b_u_mag <= u_mag_next;
      b_v_mag <= v_mag_next;
      b_u_neg <= u_sign ^ u_flip;
      b_v_neg <= v_sign ^ v_flip;
      b_degen <= a_zero_x && a_zero_y && a_zero_z;
    end
  end

  assign dn_valid   = b_valid;
  assign face       = b_face;
  assign major_mag  = b_major;
  assign u_mag      = b_u_mag;
  assign v_mag      = b_v_mag;
  assign u_neg      = b_u_neg;
  assign v_neg      = b_v_neg;
  assign degenerate = b_degen;

endmodule

### rtl/cfs_div_step.sv
module cfs_div_step import cfs_pkg::*; #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRACTION_BITS  = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  face_t                     up_face,
  input  logic                      up_degen,
  input  logic [COMPONENT_BITS-1:0] up_divisor,
  input  logic [COMPONENT_BITS-1:0] up_rem_u,
  input  logic [COMPONENT_BITS-1:0] up_rem_v,
  input  logic [FRACTION_BITS:0]    up_num_u,
  input  logic [FRACTION_BITS:0]    up_num_v,
  input  logic [FRACTION_BITS:0]    up_quot_u,
  input  logic [FRACTION_BITS:0]    up_quot_v,
  input  logic                      up_neg_u,
  input  logic                      up_neg_v,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output face_t                     dn_face,
  output logic                      dn_degen,
  output logic [COMPONENT_BITS-1:0] dn_divisor,
  output logic [COMPONENT_BITS-1:0] dn_rem_u,
  output logic [COMPONENT_BITS-1:0] dn_rem_v,
  output logic [FRACTION_BITS:0]    dn_num_u,
  output logic [FRACTION_BITS:0]    dn_num_v,
  output logic [FRACTION_BITS:0]    dn_quot_u,
  output logic [FRACTION_BITS:0]    dn_quot_v,
  output logic                      dn_neg_u,
  output logic                      dn_neg_v
);

  localparam int C = COMPONENT_BITS;
  localparam int F = FRACTION_BITS;

  logic         valid;
  logic [C:0]   trial_u, trial_v, diff_u, diff_v;
  logic         ge_u, ge_v;

  // one restoring step per lane: bring down the next numerator bit
  assign trial_u = {up_rem_u, up_num_u[F]};
  assign trial_v = {up_rem_v, up_num_v[F]};
  assign diff_u  = trial_u - {1'b0, up_divisor};
  assign diff_v  = trial_v - {1'b0, up_divisor};
  assign ge_u    = (trial_u >= {1'b0, up_divisor});
  assign ge_v    = (trial_v >= {1'b0, up_divisor});

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
    if (up_valid && up_ready) begin
      dn_face    <= up_face;
      dn_degen   <= up_degen;
      dn_divisor <= up_divisor;
      dn_rem_u   <= ge_u ? diff_u[C-1:0] : trial_u[C-1:0];
      dn_rem_v   <= ge_v ? diff_v[C-1:0] : trial_v[C-1:0];
      dn_num_u   <= {up_num_u[F-1:0], 1'b0};
      dn_num_v   <= {up_num_v[F-1:0], 1'b0};
      dn_quot_u  <= {up_quot_u[F-1:0], ge_u};
      dn_quot_v  <= {up_quot_v[F-1:0], ge_v};
      dn_neg_u   <= up_neg_u;
      dn_neg_v   <= up_neg_v;
    end
  end

  assign dn_valid = valid;

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import cfs_pkg::*;

  localparam int COMPONENT_BITS = 16;
  localparam int FRACTION_BITS  = 14;
  localparam int CB = COMPONENT_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 420;

  // expected face results, oldest first, with the face arithmetic beside them
  class face_scoreboard;
    typedef struct {
      face_t             face;
      logic signed [FB+1:0] u;
      logic signed [FB+1:0] v;
      logic              degenerate;
    } face_result_t;

    face_result_t expected_faces[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // magnitude one bit wider, so the most negative component is exact
    function automatic logic [CB:0] magnitude(logic signed [CB-1:0] c);
      logic [CB:0] w;
      w = {c[CB-1], c};
      return c[CB-1] ? (~w + 1'b1) : w;
    endfunction

    // rounded |n| / m in Q1.FB, ties away from zero, sign applied afterwards
    function automatic logic signed [FB+1:0] scaled_coord(logic signed [CB-1:0] n,
                                                          logic [CB:0] m, bit flip);
      logic [2*CB+1:0] q;
      logic [FB+1:0]   qn;
      if (m == 0) return '0;
      q = (((2*CB+2)'(magnitude(n)) << FB) + (2*CB+2)'(m >> 1)) / (2*CB+2)'(m);
      qn = q[FB+1:0];
      return (n[CB-1] ^ flip) ? -qn : qn;
    endfunction

    function automatic face_result_t predict_face(logic signed [CB-1:0] x,
                                                  logic signed [CB-1:0] y,
                                                  logic signed [CB-1:0] z);
      face_result_t r;
      logic [CB:0] ax, ay, az;
      ax = magnitude(x);
      ay = magnitude(y);
      az = magnitude(z);
      // strict compares: ties drop through to y, then z
      if (ax > ay && ax > az) begin
        r.face = (x > 0) ? FACE_POS_X : FACE_NEG_X;
        r.u = scaled_coord(z, ax, r.face == FACE_POS_X);
        r.v = scaled_coord(y, ax, 1'b1);
      end else if (ay > az) begin
        r.face = (y > 0) ? FACE_POS_Y : FACE_NEG_Y;
        r.u = scaled_coord(x, ay, 1'b0);
        r.v = scaled_coord(z, ay, r.face == FACE_NEG_Y);
      end else begin
        r.face = (z > 0) ? FACE_POS_Z : FACE_NEG_Z;
        r.u = scaled_coord(x, az, r.face == FACE_NEG_Z);
        r.v = scaled_coord(y, az, 1'b1);
      end
      r.degenerate = (ax == 0 && ay == 0 && az == 0);
      return r;
    endfunction

    function void note_direction(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                                 logic signed [CB-1:0] z);
      expected_faces.push_back(predict_face(x, y, z));
    endfunction

    function void check_face(logic [2:0] face, logic signed [FB+1:0] u,
                             logic signed [FB+1:0] v, logic degenerate);
      face_result_t e;
      if (expected_faces.size() == 0) begin
        errors++;
        $error("face result transfer with nothing outstanding");
        return;
      end
      e = expected_faces.pop_front();
      if (face !== e.face) begin
        errors++;
        $error("face_index: expected %0d, actual %0d", e.face, face);
      end
      if (u !== e.u) begin
        errors++;
        $error("u_coord: expected %0d, actual %0d", e.u, u);
      end
      if (v !== e.v) begin
        errors++;
        $error("v_coord: expected %0d, actual %0d", e.v, v);
      end
      if (degenerate !== e.degenerate) begin
        errors++;
        $error("degenerate: expected %0b, actual %0b", e.degenerate, degenerate);
      end
    endfunction

    function int pending();
      return expected_faces.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  cfs_dir_if  #(.COMPONENT_BITS(CB)) dir ();
  cfs_face_if #(.FRACTION_BITS(FB))  res ();

  cubemap_face_select_core #(
    .COMPONENT_BITS(CB),
    .FRACTION_BITS (FB)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .dir(dir),
    .res(res)
  );

  face_scoreboard faces = new();

  int send_idle_pct;
  int stall_pct;
  int hold_asked;
  int hold_seen = 0;
  int hold_left = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // overall time limit
  initial begin
    #1000000;
    $display("tb: errors");
    $finish;
  end

  // result side: check each transfer, stall at random or hold off on request
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      faces.check_face(res.face_index, res.u_coord, res.v_coord, res.degenerate);
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_asked != hold_seen) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one direction, idling first at random, until it is taken
  task automatic send_direction(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
                                input logic signed [CB-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      dir.valid <= 1'b0;
      @(posedge clk);
    end
    dir.valid       <= 1'b1;
    dir.x_component <= x;
    dir.y_component <= y;
    dir.z_component <= z;
    do @(posedge clk); while (!dir.ready);
    faces.note_direction(x, y, z);
  endtask

  // sender pauses until every outstanding face has come back
  task automatic drain_faces();
    dir.valid <= 1'b0;
    while (faces.pending() != 0) @(posedge clk);
  endtask

  // one random component no larger than m in magnitude
  function automatic logic signed [CB-1:0] bounded_component(int m);
    return CB'($urandom_range(2 * m) - m);
  endfunction

  task automatic send_random_direction();
    logic signed [CB-1:0] a, b, c;
    int m;
    m = $urandom_range(32767, 1);
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        // whole bit patterns, the most negative value among them
        a = CB'($urandom);
        b = CB'($urandom);
        c = CB'($urandom);
      end
      4, 5: begin
        // tiny vectors: ties and the zero vector turn up often
        a = bounded_component(3);
        b = bounded_component(3);
        c = bounded_component(3);
      end
      6: begin
        // equal magnitudes on two or three axes
        a = $urandom_range(1) ? CB'(m) : CB'(-m);
        b = $urandom_range(1) ? CB'(m) : CB'(-m);
        c = $urandom_range(1) ? ($urandom_range(1) ? CB'(m) : CB'(-m)) : bounded_component(m);
      end
      7: begin
        // one axis at the extremes
        case ($urandom_range(2))
          0: a = CB'(32767);
          1: a = CB'(-32767);
          default: a = CB'(-32768);
        endcase
        b = CB'($urandom);
        c = CB'($urandom);
      end
      8: begin
        // major axis with minors just below it, or nothing at all
        if ($urandom_range(3) == 0) begin
          a = '0;
          b = '0;
          c = '0;
        end else begin
          a = CB'(m);
          b = $urandom_range(1) ? CB'(m - 1) : CB'(1 - m);
          c = bounded_component(m - 1);
        end
      end
      default: begin
        // minors anywhere within the major magnitude
        a = $urandom_range(1) ? CB'(m) : CB'(-m);
        b = bounded_component(m);
        c = bounded_component(m);
      end
    endcase
    // rotate so the chosen major lands on any axis
    case ($urandom_range(2))
      0: send_direction(a, b, c);
      1: send_direction(c, a, b);
      default: send_direction(b, c, a);
    endcase
  endtask

  // stimulus
  initial begin
    rst             = 1'b1;
    dir.valid       = 1'b0;
    dir.x_component = '0;
    dir.y_component = '0;
    dir.z_component = '0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_asked      = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: each face, zero vector, ties, most negative value, rounding
    send_direction(0, 0, 0);
    send_direction(1000, 0, 0);
    send_direction(-1000, 0, 0);
    send_direction(0, 1000, 0);
    send_direction(0, -1000, 0);
    send_direction(0, 0, 1000);
    send_direction(0, 0, -1000);
    send_direction(32767, -32767, 32766);
    send_direction(-32767, 32766, -32766);
    send_direction(500, 500, 100);
    send_direction(-500, 100, 500);
    send_direction(100, -700, 700);
    send_direction(-300, -300, -300);
    send_direction(-32768, 0, 0);
    send_direction(-32768, -32768, -32768);
    send_direction(0, -32768, 32767);
    send_direction(32767, 32767, -32768);
    send_direction(1, 0, -32768);
    send_direction(32767, 1, -1);
    send_direction(3, 1, 2);
    send_direction(0, 0, 1);
    send_direction(0, 0, -1);
    send_direction(-1, 0, 0);
    send_direction(-1, -1, -1);
    drain_faces();

    // long hold-off on the result side while directions keep coming
    hold_asked <= hold_asked + 1;
    repeat (80) send_random_direction();
    drain_faces();

    // random traffic under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      repeat (ITEMS_PER_PHASE) send_random_direction();
      drain_faces();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (faces.errors == 0 && faces.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
